// File: hdl/hps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants for the Hamiltonian path search
// Field widths, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int VERTEX_W   = 4;
  localparam int WEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_CYCLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = CFG_IDX_W'(1);

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/hps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_if: item channels of the Hamiltonian path search
// Input item channel, result item channel and configuration write channel.
// ----------------------------------------------------------------------------
interface hps_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic        [hps_pkg::VERTEX_W-1:0]   row_vertex;
  logic        [hps_pkg::VERTEX_W-1:0]   col_vertex;
  logic signed [hps_pkg::WEIGHT_W-1:0]   weight;
  logic        [hps_pkg::VERTEX_W-1:0]   start_vertex;

  modport source (output valid, kind, row_vertex, col_vertex, weight, start_vertex,
                  input ready);
  modport sink (input valid, kind, row_vertex, col_vertex, weight, start_vertex,
                output ready);
endinterface

interface hps_out_if;
  logic                           valid;
  logic                           ready;
  logic [hps_pkg::VERTEX_W-1:0]   vertex;
  logic                           found;
  logic                           last;

  modport source (output valid, vertex, found, last, input ready);
  modport sink (input valid, vertex, found, last, output ready);
endinterface

interface hps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hps_pkg::CFG_IDX_W-1:0]    index;
  logic [hps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/hamiltonian_path_search.sv
`timescale 1ns / 1ps
// Load: a load item is taken in its accept cycle and input ready stays high.
// A search item holds ready low from its accept until its last result is registered,
// through every rejected candidate, push, pop and closing check, then every emitted
// result, plus any stalls on the result side.
// Throughput: one neighbor test per cycle; one result per cycle while ready is high.
// Reset: synchronous; clears matrix, sequencer and result valid; cycle mode, 16 vertices.
// ----------------------------------------------------------------------------
// hamiltonian_path_search: depth-first Hamiltonian path / cycle search
// Loads an adjacency matrix one entry per item, then searches for a path (or
// cycle) that visits every vertex in use, with an explicit stack, and streams
// the path out one vertex per result item.
// ----------------------------------------------------------------------------
module hamiltonian_path_search #(
  parameter int MAX_VERTICES = 16
) (
  input  logic         clk,
  input  logic         rst,
  hps_in_if.sink       item_in,
  hps_out_if.source    item_out,
  hps_cfg_if.sink      cfg
);

  // Vertex index width and a count width that can hold MAX_VERTICES itself
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // Configuration registers
  logic                          require_cycle;
  logic [hps_pkg::COUNT_W-1:0]   vertex_count;

  // Adjacency matrix: one row of edge bits per source vertex
  logic [MAX_VERTICES-1:0]       edge_bits [MAX_VERTICES];

  // Search stack: path vertex and resume cursor per level
  logic [VW-1:0]                 path_stack [MAX_VERTICES];
  logic [CW-1:0]                 next_cand  [MAX_VERTICES];

  // Sequencer and working registers
  hps_pkg::state_t               state, state_next;
  logic [CW-1:0]                 depth, depth_next;
  logic [VW-1:0]                 top, top_next;
  logic [CW-1:0]                 cand, cand_next;
  logic [MAX_VERTICES-1:0]       visited, visited_next;
  logic [CW-1:0]                 n_run, n_run_next;
  logic [hps_pkg::VERTEX_W-1:0]  start_v, start_v_next;
  logic                          found_r, found_r_next;
  logic [VW-1:0]                 emit_idx, emit_idx_next;

  // Output register
  logic                          out_valid, out_valid_next;
  logic [hps_pkg::VERTEX_W-1:0]  out_vertex, out_vertex_next;
  logic                          out_found, out_found_next;
  logic                          out_last, out_last_next;

  // Stack write ports
  logic                          ps_we;
  logic [VW-1:0]                 ps_waddr;
  logic [VW-1:0]                 ps_wdata;
  logic                          nc_we;
  logic [VW-1:0]                 nc_waddr;
  logic [CW-1:0]                 nc_wdata;

  // Shared read taps
  logic [VW-1:0]                 rd_idx;
  logic [VW-1:0]                 ps_rd;
  logic [CW-1:0]                 nc_rd;
  logic [MAX_VERTICES-1:0]       edge_row;
  logic [VW-1:0]                 cand_idx;
  logic [VW-1:0]                 pop_idx;
  logic [CW-1:0]                 n_cur;
  logic                          in_accept;
  logic                          load_en;
  logic                          load_edge;
  logic [VW-1:0]                 load_row;
  logic [VW-1:0]                 load_col;
  logic                          close_ok;
  logic [MAX_VERTICES-1:0]       one_hot_base;

  assign one_hot_base = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  assign item_in.ready = (state == hps_pkg::ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_accept     = item_in.valid && item_in.ready;

  assign item_out.valid  = out_valid;
  assign item_out.vertex = out_vertex;
  assign item_out.found  = out_found;
  assign item_out.last   = out_last;

  // Vertices in use: zero counts as one, anything above the matrix saturates
  always_comb begin
    if (vertex_count == '0) begin
      n_cur = CW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_cur = CW'(MAX_VERTICES);
    end else begin
      n_cur = CW'(vertex_count);
    end
  end

  // Load decode: an entry is an edge when its signed weight is above zero
  assign load_en   = in_accept && (item_in.kind == hps_pkg::KIND_LOAD) &&
                     (32'(item_in.row_vertex) < MAX_VERTICES) &&
                     (32'(item_in.col_vertex) < MAX_VERTICES);
  assign load_edge = (item_in.weight > 16'sd0);
  assign load_row  = VW'(item_in.row_vertex);
  assign load_col  = VW'(item_in.col_vertex);

  // One read address for the stack: the emit index while streaming, else the
  // level under the top (where a pop resumes)
  assign pop_idx  = VW'(depth - CW'(2));
  assign rd_idx   = (state == hps_pkg::ST_EMIT) ? emit_idx : pop_idx;
  assign ps_rd    = path_stack[rd_idx];
  assign nc_rd    = next_cand[rd_idx];
  assign edge_row = edge_bits[top];
  assign cand_idx = cand[VW-1:0];
  assign close_ok = !require_cycle || edge_row[VW'(start_v)];

  // Sequencer: next state, working registers and output register
  always_comb begin
    state_next      = state;
    depth_next      = depth;
    top_next        = top;
    cand_next       = cand;
    visited_next    = visited;
    n_run_next      = n_run;
    start_v_next    = start_v;
    found_r_next    = found_r;
    emit_idx_next   = emit_idx;
    out_valid_next  = out_valid && !item_out.ready;
    out_vertex_next = out_vertex;
    out_found_next  = out_found;
    out_last_next   = out_last;
    ps_we           = 1'b0;
    ps_waddr        = '0;
    ps_wdata        = '0;
    nc_we           = 1'b0;
    nc_waddr        = '0;
    nc_wdata        = '0;

    unique case (state)
      hps_pkg::ST_IDLE: begin
        if (in_accept && (item_in.kind == hps_pkg::KIND_SEARCH)) begin
          start_v_next  = item_in.start_vertex;
          n_run_next    = n_cur;
          found_r_next  = 1'b0;
          emit_idx_next = '0;
          if (32'(item_in.start_vertex) < 32'(n_cur)) begin
            // Seed the stack with the start vertex
            visited_next = one_hot_base << VW'(item_in.start_vertex);
            ps_we        = 1'b1;
            ps_waddr     = '0;
            ps_wdata     = VW'(item_in.start_vertex);
            depth_next   = CW'(1);
            top_next     = VW'(item_in.start_vertex);
            cand_next    = '0;
            state_next   = (n_cur == CW'(1)) ? hps_pkg::ST_CLOSE : hps_pkg::ST_SCAN;
          end else begin
            // Start outside the vertices in use: report failure at once
            state_next = hps_pkg::ST_EMIT;
          end
        end
      end

      hps_pkg::ST_SCAN: begin
        if (cand < n_run) begin
          if (edge_row[cand_idx] && !visited[cand_idx]) begin
            // Push: remember where this level resumes, descend into the candidate
            nc_we        = 1'b1;
            nc_waddr     = VW'(depth - CW'(1));
            nc_wdata     = cand + CW'(1);
            ps_we        = 1'b1;
            ps_waddr     = VW'(depth);
            ps_wdata     = cand_idx;
            visited_next = visited | (one_hot_base << cand_idx);
            depth_next   = depth + CW'(1);
            top_next     = cand_idx;
            cand_next    = '0;
            if (depth + CW'(1) == n_run) begin
              state_next = hps_pkg::ST_CLOSE;
            end
          end else begin
            cand_next = cand + CW'(1);
          end
        end else begin
          // Neighbors exhausted: drop the top vertex
          visited_next = visited & ~(one_hot_base << top);
          if (depth == CW'(1)) begin
            depth_next = '0;
            state_next = hps_pkg::ST_EMIT;
          end else begin
            depth_next = depth - CW'(1);
            top_next   = ps_rd;
            cand_next  = nc_rd;
          end
        end
      end

      hps_pkg::ST_CLOSE: begin
        if (close_ok) begin
          found_r_next = 1'b1;
          state_next   = hps_pkg::ST_EMIT;
        end else if (depth == CW'(1)) begin
          // Single vertex without a self edge
          state_next = hps_pkg::ST_EMIT;
        end else begin
          // Full length but not closing: back off one level and keep scanning
          visited_next = visited & ~(one_hot_base << top);
          depth_next   = depth - CW'(1);
          top_next     = ps_rd;
          cand_next    = nc_rd;
          state_next   = hps_pkg::ST_SCAN;
        end
      end

      hps_pkg::ST_EMIT: begin
        if (!out_valid || item_out.ready) begin
          out_valid_next = 1'b1;
          out_found_next = found_r;
          if (found_r) begin
            out_vertex_next = hps_pkg::VERTEX_W'(ps_rd);
            out_last_next   = (emit_idx == VW'(depth - CW'(1)));
          end else begin
            out_vertex_next = start_v;
            out_last_next   = 1'b1;
          end
          if (!found_r || (emit_idx == VW'(depth - CW'(1)))) begin
            state_next = hps_pkg::ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + VW'(1);
          end
        end
      end

      default: begin
        state_next = hps_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth         <= '0;
      visited       <= '0;
      out_valid     <= 1'b0;
      require_cycle <= 1'b1;
      vertex_count  <= hps_pkg::COUNT_W'(16);
    end else begin
      depth     <= depth_next;
      visited   <= visited_next;
      out_valid <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          hps_pkg::CFG_REQUIRE_CYCLE: require_cycle <= cfg.data[0];
          hps_pkg::CFG_VERTEX_COUNT:  vertex_count  <= cfg.data[hps_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Adjacency matrix, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        edge_bits[r] <= '0;
      end
    end else if (load_en) begin
      edge_bits[load_row][load_col] <= load_edge;
    end
  end

  // Payload registers and stack storage
  always_ff @(posedge clk) begin
    top        <= top_next;
    cand       <= cand_next;
    n_run      <= n_run_next;
    start_v    <= start_v_next;
    found_r    <= found_r_next;
    emit_idx   <= emit_idx_next;
    out_vertex <= out_vertex_next;
    out_found  <= out_found_next;
    out_last   <= out_last_next;
    if (ps_we) begin
      path_stack[ps_waddr] <= ps_wdata;
    end
    if (nc_we) begin
      next_cand[nc_waddr] <= nc_wdata;
    end
  end

endmodule

// File: hdl/hps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_checker: port-level checks for the Hamiltonian path search
// Watches the item channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module hps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_kind,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hps_pkg::VERTEX_W-1:0]   out_vertex,
  input logic                           out_found,
  input logic                           out_last
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex) &&
                                $stable(out_found) && $stable(out_last))
    else $error("result item changed while stalled");

  // A search holds off the input for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == hps_pkg::KIND_SEARCH) |=> !in_ready)
    else $error("input ready right after a search item");

  // After a load item the input is ready again in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_kind == hps_pkg::KIND_LOAD) |=> in_ready)
    else $error("input not ready after a load item");

  // Only a found path spans several result items
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_found)
    else $error("failure run longer than one item");

endmodule

bind hamiltonian_path_search hps_checker u_hps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (item_in.valid),
  .in_ready   (item_in.ready),
  .in_kind    (item_in.kind),
  .out_valid  (item_out.valid),
  .out_ready  (item_out.ready),
  .out_vertex (item_out.vertex),
  .out_found  (item_out.found),
  .out_last   (item_out.last)
);

// File: tb/hamiltonian_path_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamiltonian_path_search_test: self-checking bench for the path search block
// Loads adjacency entries and launches searches through the item channel,
// predicts every emitted path vertex with an in-bench depth-first search, and
// compares each result item field by field, with random gaps on both sides,
// a long output hold-off and several register settings.
// ----------------------------------------------------------------------------
module hamiltonian_path_search_test;

  localparam int MAX_V         = 16;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SEARCH_BUDGET = 600;   // cap on scan work per random search
  localparam int SETTLE_CYCLES = 8;     // covers a trailing load still in flight
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 175;

  typedef struct packed {
    logic                         kind;
    logic [hps_pkg::VERTEX_W-1:0] row_v;
    logic [hps_pkg::VERTEX_W-1:0] col_v;
    logic [hps_pkg::WEIGHT_W-1:0] weight;
    logic [hps_pkg::VERTEX_W-1:0] start_v;
  } graph_item_t;

  typedef struct packed {
    logic [hps_pkg::VERTEX_W-1:0] vertex;
    logic                         found;
    logic                         last;
  } path_step_t;

  logic clk;
  logic rst;

  hps_in_if  in_ch();
  hps_out_if out_ch();
  hps_cfg_if cfg_ch();

  hamiltonian_path_search #(.MAX_VERTICES(MAX_V)) dut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (in_ch),
    .item_out (out_ch),
    .cfg      (cfg_ch)
  );

  // Bench copy of the block state: adjacency bits and both registers.
  logic [MAX_V-1:0] adj_rows [MAX_V];
  logic             cycle_req;
  logic [4:0]       vcount_cfg;

  // Scratch output of the path search.
  int route_v [MAX_V];
  int route_len;
  bit route_hit;

  path_step_t route_steps[$];   // vertices still owed by the block, oldest first
  int         mismatches;
  int         items_sent;
  int         cycle_count;
  int         hold_left;
  int         stall_left;
  bit         steady;           // no gaps on either side while set

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hamiltonian_path_search_test: errors");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Vertices in use: zero acts as one, anything past the store saturates.
  function automatic int live_vertices();
    int n;
    n = int'(vcount_cfg);
    if (n == 0) n = 1;
    if (n > MAX_V) n = MAX_V;
    return n;
  endfunction

  // Depth-first search with an explicit stack, neighbors in ascending order.
  // Fill route_v / route_len / route_hit; return the scan work spent. Stop early
  // once the work passes the budget (route_hit stays clear then).
  function automatic int trace_route(input int start, input int budget);
    int               n;
    int               stk [MAX_V];
    int               nxt [MAX_V];
    logic [MAX_V-1:0] seen;
    int               depth;
    int               work;
    int               lvl;
    int               top;
    int               i;
    n         = live_vertices();
    route_hit = 1'b0;
    route_len = 0;
    work      = 0;
    if (start >= n) return 0;
    seen   = '0;
    seen[start] = 1'b1;
    stk[0] = start;
    nxt[0] = 0;
    depth  = 1;
    // a lone vertex is a full path already; a cycle needs its self loop
    if (n == 1 && (!cycle_req || adj_rows[start][start])) route_hit = 1'b1;
    while (depth > 0 && !route_hit && work <= budget) begin
      lvl = depth - 1;
      top = stk[lvl];
      i   = nxt[lvl];
      while (i < n && !(adj_rows[top][i] && !seen[i])) begin
        i++;
        work++;
      end
      work++;
      if (i < n) begin
        nxt[lvl]   = i + 1;
        stk[depth] = i;
        nxt[depth] = 0;
        seen[i]    = 1'b1;
        depth++;
        if (depth == n) begin
          if (!cycle_req || adj_rows[i][start]) begin
            route_hit = 1'b1;
          end else begin
            // full length but no way home: back off the last vertex
            seen[i] = 1'b0;
            depth--;
          end
        end
      end else begin
        seen[top] = 1'b0;
        depth--;
      end
    end
    if (route_hit) begin
      route_len = depth;
      for (int k = 0; k < depth; k++) route_v[k] = stk[k];
    end
    return work;
  endfunction

  // Update the bench state for one accepted item and queue what it owes.
  task automatic apply_item(input graph_item_t it);
    path_step_t step;
    if (it.kind == hps_pkg::KIND_LOAD) begin
      adj_rows[it.row_v][it.col_v] = !it.weight[hps_pkg::WEIGHT_W-1] && (it.weight != '0);
    end else begin
      void'(trace_route(int'(it.start_v), 32'h3fff_ffff));
      if (route_hit) begin
        for (int k = 0; k < route_len; k++) begin
          step.vertex = route_v[k][hps_pkg::VERTEX_W-1:0];
          step.found  = 1'b1;
          step.last   = (k == route_len - 1);
          route_steps.insert(route_steps.size(), step);
        end
      end else begin
        step.vertex = it.start_v;
        step.found  = 1'b0;
        step.last   = 1'b1;
        route_steps.insert(route_steps.size(), step);
      end
    end
  endtask

  // Offer one item after a random gap; return at the falling edge after it is
  // taken, valid still high so a back-to-back item needs no drop.
  task automatic send_item(input graph_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.kind         = it.kind;
    in_ch.row_vertex   = it.row_v;
    in_ch.col_vertex   = it.col_v;
    in_ch.weight       = it.weight;
    in_ch.start_vertex = it.start_v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Load one entry; the unused start field carries noise.
  task automatic send_load(input int r, input int c,
                           input logic [hps_pkg::WEIGHT_W-1:0] w);
    graph_item_t it;
    it.kind    = hps_pkg::KIND_LOAD;
    it.row_v   = r[hps_pkg::VERTEX_W-1:0];
    it.col_v   = c[hps_pkg::VERTEX_W-1:0];
    it.weight  = w;
    it.start_v = hps_pkg::VERTEX_W'($urandom);
    send_item(it);
  endtask

  // Launch one search; the load fields carry noise.
  task automatic send_search(input int s);
    graph_item_t it;
    it.kind    = hps_pkg::KIND_SEARCH;
    it.row_v   = hps_pkg::VERTEX_W'($urandom);
    it.col_v   = hps_pkg::VERTEX_W'($urandom);
    it.weight  = hps_pkg::WEIGHT_W'($urandom);
    it.start_v = s[hps_pkg::VERTEX_W-1:0];
    send_item(it);
  endtask

  // Drop valid, wait for every owed vertex, then let a trailing load finish.
  task automatic settle();
    in_ch.valid = 1'b0;
    wait (route_steps.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [hps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hps_pkg::CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      hps_pkg::CFG_REQUIRE_CYCLE: cycle_req  = val[0];
      hps_pkg::CFG_VERTEX_COUNT:  vcount_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Result checker: pop the oldest owed vertex on every accepted result item.
  always @(posedge clk) begin
    path_step_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (route_steps.size() == 0) begin
        $error("unexpected result item: vertex %0d found %0d last %0d",
               out_ch.vertex, out_ch.found, out_ch.last);
        mismatches++;
      end else begin
        want = route_steps.pop_front();
        if (out_ch.vertex !== want.vertex) begin
          $error("vertex: expected %0d, got %0d", want.vertex, out_ch.vertex);
          mismatches++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_ch.found);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  // Result side: drive ready at the falling edge. A requested hold-off wins,
  // otherwise stall for a random stretch after each ready cycle.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        stall_left   = pick_gap();
      end
    end
  end

  // Right after reset: empty matrix, cycle mode, all sixteen vertices.
  task automatic test_reset_defaults();
    send_search(0);
    send_search(15);
  endtask

  // One vertex in use: the start alone is the path, a cycle needs a self loop;
  // a count of zero behaves as one; starts past the count are refused.
  task automatic test_single_vertex();
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd1);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, 5'h1f);
    send_search(0);
    send_load(0, 0, 16'sh7fff);
    send_search(0);
    send_search(9);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, 5'h10);
    send_load(0, 0, 16'sh8000);
    send_search(0);
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd0);
    send_search(0);
    send_search(1);
  endtask

  // Weight sign decides the edge: zero and negative clear, positive sets.
  task automatic test_weight_sign();
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd3);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, 5'h01);
    send_load(0, 1, 16'sh0001);
    send_load(1, 2, 16'sh7fff);
    send_load(2, 0, 16'shffff);
    send_search(0);
    send_load(2, 0, 16'sh0100);
    send_search(0);
    send_search(1);
    send_load(1, 2, 16'sh0000);
    send_search(0);
  endtask

  // Counts above the store saturate to sixteen vertices.
  task automatic test_count_saturation();
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd31);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, 5'h00);
    send_search(3);
    send_search(15);
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd17);
    send_search(2);
  endtask

  // Hold the result side off for a long stretch while searches keep coming,
  // so the output backs up and the block stops taking items.
  task automatic test_backpressure();
    write_reg(hps_pkg::CFG_VERTEX_COUNT, 5'd4);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, 5'h00);
    send_load(0, 1, 16'sh1234);
    send_load(1, 2, 16'sh0042);
    send_load(2, 3, 16'sh7ffe);
    settle();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    steady = 1'b1;
    repeat (8) send_search($urandom_range(0, 5));
    steady = 1'b0;
  endtask

  // One random phase: new settings, a planted path (or not) plus noise loads,
  // then a few searches whose scan work stays within the budget.
  task automatic random_phase();
    int                            n;
    int                            r;
    int                            s;
    int                            j;
    int                            t;
    int                            perm [MAX_V];
    logic [hps_pkg::CFG_DATA_W-1:0] vc;
    r = $urandom_range(0, 19);
    if (r < 12)       vc = hps_pkg::CFG_DATA_W'($urandom_range(2, 6));
    else if (r < 15)  vc = hps_pkg::CFG_DATA_W'($urandom_range(7, 10));
    else if (r < 17)  vc = 5'd16;
    else if (r == 17) vc = hps_pkg::CFG_DATA_W'($urandom_range(0, 1));
    else              vc = hps_pkg::CFG_DATA_W'($urandom_range(17, 31));
    write_reg(hps_pkg::CFG_VERTEX_COUNT, vc);
    write_reg(hps_pkg::CFG_REQUIRE_CYCLE, hps_pkg::CFG_DATA_W'($urandom));
    // unmapped register index: accepted, changes nothing
    if ($urandom_range(0, 5) == 0)
      write_reg(hps_pkg::CFG_IDX_W'($urandom_range(2, 15)), hps_pkg::CFG_DATA_W'($urandom));
    steady = ($urandom_range(0, 4) == 0);
    n = live_vertices();
    for (int k = 0; k < n; k++) perm[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      t       = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    // most phases plant a full path (closed when a cycle is demanded)
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k + 1 < n; k++)
        send_load(perm[k], perm[k + 1], hps_pkg::WEIGHT_W'($urandom_range(1, 32767)));
      if (cycle_req)
        send_load(perm[n - 1], perm[0], hps_pkg::WEIGHT_W'($urandom_range(1, 32767)));
    end
    // noise loads may break the planted path or add shortcuts
    repeat ($urandom_range(0, n))
      send_load($urandom_range(0, 15), $urandom_range(0, 15),
                hps_pkg::WEIGHT_W'($urandom));
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 5)      s = perm[0];
      else if (r < 8) s = $urandom_range(0, n - 1);
      else            s = $urandom_range(0, 15);
      // skip starts whose backtracking would run too long
      for (int tries = 0; tries < 3 && trace_route(s, SEARCH_BUDGET) > SEARCH_BUDGET;
           tries++)
        s = $urandom_range(0, n - 1);
      if (trace_route(s, SEARCH_BUDGET) <= SEARCH_BUDGET) send_search(s);
    end
    steady = 1'b0;
  endtask

  initial begin
    // Drive every input to a known value while reset is held.
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.kind         = hps_pkg::KIND_LOAD;
    in_ch.row_vertex   = '0;
    in_ch.col_vertex   = '0;
    in_ch.weight       = '0;
    in_ch.start_vertex = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = hps_pkg::CFG_REQUIRE_CYCLE;
    cfg_ch.data        = '0;
    for (int k = 0; k < MAX_V; k++) adj_rows[k] = '0;
    cycle_req   = 1'b1;
    vcount_cfg  = 5'd16;
    mismatches  = 0;
    items_sent  = 0;
    cycle_count = 0;
    hold_left   = 0;
    stall_left  = 0;
    steady      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_single_vertex();
    test_weight_sign();
    test_count_saturation();
    test_backpressure();
    while (items_sent < ITEM_TARGET) random_phase();

    // Drain, let any stray result item show up, then report.
    settle();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("hamiltonian_path_search_test: clean");
    end else begin
      $display("hamiltonian_path_search_test: errors");
    end
    $finish;
  end

endmodule
